// ===== sv/stbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_pkg: shared types and constants for the sorted table search unit
// Table geometry, item and result layouts, function and status codes, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package stbs_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_WIDTH   = 32;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths
  localparam int FUNC_W  = 2;
  localparam int POS_W   = 10;
  localparam int KEYIN_W = 32;
  localparam int STAT_W  = 2;
  localparam int ECNT_W  = 11;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXACT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_NEAR  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_MATCH = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NEAR  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [POS_W-1:0]   load_position;
    logic [KEYIN_W-1:0] key_value;
  } stbs_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
  } stbs_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the input beat
    logic write;      // store the key of a load
    logic start;      // open a search and issue the first probe
    logic step;       // compare a probe and issue the next
    logic rec_empty;  // record the empty-table result
    logic finish;     // move the result into the output register
  } stbs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              empty;
    logic              hit;
    logic              more;
    logic              out_free;
  } stbs_stat_t;

endpackage

`default_nettype wire

// ===== sv/stbs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire                                      clk,
  input  wire                                      wr_en,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]                         wr_data,
  input  wire                                      rd_en,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/stbs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_datapath: key table, search bounds and result registers
// Holds the captured item, the entry count register, the key RAM, the
// low/high search bounds with the probe index, and the output register.
// ----------------------------------------------------------------------------
module stbs_datapath (
  input  wire                               clk,
  input  wire                               rst,
  input  wire  stbs_pkg::stbs_cmd_t         cmd,
  output stbs_pkg::stbs_stat_t              stat,
  input  wire  stbs_pkg::stbs_in_t          in_data,
  input  wire                               cfg_valid,
  input  wire  [stbs_pkg::ECNT_W-1:0]       cfg_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output stbs_pkg::stbs_out_t               out_data
);

  stbs_pkg::stbs_in_t                 item;
  logic [stbs_pkg::ECNT_W-1:0]        entry_count;
  logic [stbs_pkg::CNT_W-1:0]         lo;
  logic [stbs_pkg::CNT_W-1:0]         hi;
  logic [stbs_pkg::ADDR_W-1:0]        mid;
  stbs_pkg::stbs_out_t                res;

  logic [stbs_pkg::KEY_WIDTH-1:0]     key_s;
  logic [stbs_pkg::KEY_WIDTH-1:0]     probe;
  logic [stbs_pkg::CNT_W-1:0]         count_c;
  logic [stbs_pkg::CNT_W-1:0]         lo_upd;
  logic [stbs_pkg::CNT_W-1:0]         hi_upd;
  logic [stbs_pkg::CNT_W:0]           mid_sum;
  logic [stbs_pkg::ADDR_W-1:0]        mid_calc;
  logic                               lt;
  logic                               gt;
  logic                               hit;
  logic                               more;
  logic                               wr_ok;
  logic [stbs_pkg::POS_W-1:0]         mid_pos;

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
  end

  // Entry count register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid) begin
      entry_count <= cfg_data;
    end
  end

  // Clamp the count to the table depth
  always_comb begin
    if (32'(entry_count) > 32'(stbs_pkg::TABLE_DEPTH)) begin
      count_c = stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH);
    end else begin
      count_c = stbs_pkg::CNT_W'(entry_count);
    end
  end

  // Key compare against the registered probe
  assign key_s = stbs_pkg::KEY_WIDTH'(item.key_value);
  assign lt    = probe < key_s;
  assign gt    = probe > key_s;
  assign hit   = !lt && !gt;

  // Next bounds; hi is kept as an exclusive bound
  always_comb begin
    if (cmd.start) begin
      lo_upd = '0;
      hi_upd = count_c;
    end else begin
      lo_upd = lt ? (stbs_pkg::CNT_W'(mid) + stbs_pkg::CNT_W'(1)) : lo;
      hi_upd = gt ? stbs_pkg::CNT_W'(mid) : hi;
    end
  end

  assign more     = lo_upd < hi_upd;
  assign mid_sum  = (stbs_pkg::CNT_W+1)'(lo_upd) + (stbs_pkg::CNT_W+1)'(hi_upd)
                    - (stbs_pkg::CNT_W+1)'(1);
  assign mid_calc = stbs_pkg::ADDR_W'(mid_sum >> 1);
  assign mid_pos  = stbs_pkg::POS_W'(mid);

  // Advance bounds and probe index
  always_ff @(posedge clk) begin
    if (cmd.start || cmd.step) begin
      lo <= lo_upd;
      hi <= hi_upd;
      if (more) begin
        mid <= mid_calc;
      end
    end
  end

  // Record the result of a search
  always_ff @(posedge clk) begin
    if (cmd.rec_empty) begin
      res.status   <= stbs_pkg::ST_EMPTY;
      res.position <= '0;
    end else if (cmd.step) begin
      if (hit) begin
        res.status   <= stbs_pkg::ST_MATCH;
        res.position <= mid_pos;
      end else if (item.func == stbs_pkg::FUNC_NEAR) begin
        res.status   <= stbs_pkg::ST_NEAR;
        res.position <= mid_pos;
      end else begin
        res.status   <= stbs_pkg::ST_MISS;
        res.position <= '0;
      end
    end
  end

  // Key table
  assign wr_ok = 32'(item.load_position) < 32'(stbs_pkg::TABLE_DEPTH);

  stbs_ram #(
    .WIDTH (stbs_pkg::KEY_WIDTH),
    .DEPTH (stbs_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.write && wr_ok),
    .wr_addr (stbs_pkg::ADDR_W'(item.load_position)),
    .wr_data (key_s),
    .rd_en   ((cmd.start || cmd.step) && more),
    .rd_addr (mid_calc),
    .rd_data (probe)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= res;
    end
  end

  // Status to the controller
  always_comb begin
    stat.func     = item.func;
    stat.empty    = count_c == '0;
    stat.hit      = hit;
    stat.more     = more;
    stat.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ===== sv/stbs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_ctrl: search sequencer
// Takes one item at a time, dispatches loads and searches, steps the probe
// loop and hands the result to the output register.
// ----------------------------------------------------------------------------
module stbs_ctrl (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  output stbs_pkg::stbs_cmd_t        cmd,
  input  wire  stbs_pkg::stbs_stat_t stat
);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_DISPATCH = 2'd1;
  localparam logic [1:0] S_SEARCH   = 2'd2;
  localparam logic [1:0] S_DONE     = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = state == S_IDLE;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.func)
          stbs_pkg::FUNC_LOAD: begin
            cmd.write  = 1'b1;
            state_next = S_IDLE;
          end
          stbs_pkg::FUNC_EXACT, stbs_pkg::FUNC_NEAR: begin
            if (stat.empty) begin
              cmd.rec_empty = 1'b1;
              state_next    = S_DONE;
            end else begin
              cmd.start  = 1'b1;
              state_next = S_SEARCH;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_SEARCH: begin
        cmd.step = 1'b1;
        if (stat.hit || !stat.more) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sorted_table_binary_search_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit: sorted key table with binary search
// Items are taken one at a time. A load returns to accepting once its key
// is written. A search issues P probes before its result beat is offered,
// where P is at most ceil(log2(n + 1)) for n entries in use; each probe is
// one read of the key RAM plus one compare, through the RAM's single read
// port. A finished result waits in an output register while the next item
// is accepted. The user must write entry_count on the cfg port only while
// no item is in flight, and the block does not enforce this; table entries
// must be loaded before a search can reach them.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  stbs_pkg::stbs_in_t         in_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output stbs_pkg::stbs_out_t              out_data,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [stbs_pkg::ECNT_W-1:0]      cfg_data
);

  stbs_pkg::stbs_cmd_t  cmd;
  stbs_pkg::stbs_stat_t stat;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  stbs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
